// ===== design/signed_bcd_add_sub_mul_assert.svh =====
// assertion macros for the signed bcd arithmetic unit
`ifndef SIGNED_BCD_ADD_SUB_MUL_ASSERT_SVH
`define SIGNED_BCD_ADD_SUB_MUL_ASSERT_SVH
`ifndef ASSERT_OFF
`define SBA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SBA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== design/sbcd_pkg.sv =====
// shared types and constants for the signed bcd arithmetic unit
package sbcd_pkg;
  localparam int MAX_DIGITS = 16;
  localparam int MAG_W = 64;
  // one product column: up to sixteen digit products plus the incoming tens
  localparam int COL_W = 12;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_RSV = 2'd3
  } op_t;

  // request payload
  typedef struct packed {
    op_t req_type;
    logic a_negative;
    logic [MAG_W-1:0] a_magnitude;
    logic b_negative;
    logic [MAG_W-1:0] b_magnitude;
  } req_t;

  // result payload
  typedef struct packed {
    logic result_negative;
    logic [MAG_W-1:0] result_low_digits;
    logic [MAG_W-1:0] result_high_digits;
    logic bad_digit;
  } res_t;

  // control that travels with an item along the row
  typedef struct packed {
    logic valid;
    op_t  op;
    logic bad;
    logic sub_mode;
    logic swap;
    logic neg;
  } ctl_t;

  // tens of a column value, by reciprocal multiplication (exact below 16384)
  function automatic logic [COL_W-1:0] bcd_carry(input logic [COL_W-1:0] v);
    logic [2*COL_W-1:0] p;
    p = (2*COL_W)'(v) * (2*COL_W)'(3277);
    return COL_W'(p[2*COL_W-1:15]);
  endfunction
endpackage

// ===== design/sbcd_if.sv =====
// valid/ready channel carrying request or result payload
interface sbcd_req_if;
  import sbcd_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbcd_res_if;
  import sbcd_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/sbcd_cell.sv =====
// one cell of the row: handles digit position POS of a and b, or a[POS] times all of b, per cycle while en is high
module sbcd_cell
  import sbcd_pkg::*;
#(
  parameter int DIGITS = 16,
  parameter int POS = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  logic [4*DIGITS-1:0]  a_in,
  input  logic [4*DIGITS-1:0]  b_in,
  input  logic [COL_W*2*DIGITS-1:0] acc_in,
  input  logic                 cy_in,
  output ctl_t                 ctl_out,
  output logic [4*DIGITS-1:0]  a_out,
  output logic [4*DIGITS-1:0]  b_out,
  output logic [COL_W*2*DIGITS-1:0] acc_out,
  output logic                 cy_out
);
  ctl_t ctl_r;
  logic [4*DIGITS-1:0] a_r, b_r;
  logic [COL_W*2*DIGITS-1:0] acc_r, acc_nxt;
  logic cy_r, cy_nxt;
  logic [3:0] da, db, big, sml;
  logic [4:0] s;
  logic [4:0] t;
  logic [COL_W-1:0] c;

  // digit operation at this position
  always_comb begin
    acc_nxt = acc_in;
    cy_nxt = cy_in;
    c = '0;
    da = a_in[4*POS +: 4];
    db = b_in[4*POS +: 4];
    big = ctl_in.swap ? db : da;
    sml = ctl_in.swap ? da : db;
    s = 5'(sml) + 5'(cy_in);
    t = 5'(da) + 5'(db) + 5'(cy_in);
    if (ctl_in.op == OP_MUL) begin
      // accumulate a[pos] times every b digit into columns pos..pos+DIGITS-1
      for (int j = 0; j < DIGITS; j++) begin
        acc_nxt[COL_W*(POS+j) +: COL_W] = acc_in[COL_W*(POS+j) +: COL_W] +
          COL_W'(da) * COL_W'(b_in[4*j +: 4]);
      end
      // column pos gets nothing more: settle it and pass its tens on
      c = bcd_carry(acc_nxt[COL_W*POS +: COL_W]);
      acc_nxt[COL_W*POS +: COL_W] = acc_nxt[COL_W*POS +: COL_W] - c * COL_W'(10);
      acc_nxt[COL_W*(POS+1) +: COL_W] = acc_nxt[COL_W*(POS+1) +: COL_W] + c;
    end else if (ctl_in.sub_mode) begin
      if (5'(big) >= s) begin
        acc_nxt[COL_W*POS +: COL_W] = COL_W'(5'(big) - s);
        cy_nxt = 1'b0;
      end else begin
        acc_nxt[COL_W*POS +: COL_W] = COL_W'(5'(big) + 5'd10 - s);
        cy_nxt = 1'b1;
      end
    end else begin
      cy_nxt = (t >= 5'd10);
      acc_nxt[COL_W*POS +: COL_W] = COL_W'(cy_nxt ? t - 5'd10 : t);
      if (POS == DIGITS-1) acc_nxt[COL_W*DIGITS +: COL_W] = COL_W'(cy_nxt);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
    if (en) begin
      a_r <= a_in;
      b_r <= b_in;
      acc_r <= acc_nxt;
      cy_r <= cy_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign a_out = a_r;
  assign b_out = b_r;
  assign acc_out = acc_r;
  assign cy_out = cy_r;
endmodule

// ===== design/sbcd_norm_cell.sv =====
// one carry normalising cell: settles column POS of the product
module sbcd_norm_cell
  import sbcd_pkg::*;
#(
  parameter int DIGITS = 16,
  parameter int POS = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ctl_t                  ctl_in,
  input  logic [COL_W*2*DIGITS-1:0] acc_in,
  output ctl_t                  ctl_out,
  output logic [COL_W*2*DIGITS-1:0] acc_out
);
  ctl_t ctl_r;
  logic [COL_W*2*DIGITS-1:0] acc_r, acc_nxt;
  logic [COL_W-1:0] c;

  // push the tens of this column into the next one
  always_comb begin
    acc_nxt = acc_in;
    c = bcd_carry(acc_in[COL_W*POS +: COL_W]);
    if (ctl_in.op == OP_MUL) begin
      acc_nxt[COL_W*POS +: COL_W] = acc_in[COL_W*POS +: COL_W] - c * COL_W'(10);
      acc_nxt[COL_W*(POS+1) +: COL_W] = acc_in[COL_W*(POS+1) +: COL_W] + c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
    if (en) acc_r <= acc_nxt;
  end

  assign ctl_out = ctl_r;
  assign acc_out = acc_r;
endmodule

// ===== design/signed_bcd_add_sub_mul.sv =====
// Signed packed-bcd add, subtract and multiply unit, top level.
// The request channel in_ carries the operation and two sign-magnitude
// operands of DIGITS packed bcd digits; the result channel out_ carries the
// sign, the low and high DIGITS digits of the result and a bad digit flag.
// One result per request, in order. Throughput is one request per cycle
// while the receiver does not stall. From request to result: the decode is
// combinational, then DIGITS digit cells (one digit position each: add/borrow
// chain, or one row of partial products that also settles its own column),
// DIGITS-1 carry normalising cells for the upper half of products, and the
// output register.
// The whole row advances together; when the receiver stalls with a result
// waiting, the row holds and in_ready drops only if the output register is
// full and not being taken.
// Reset clears every valid bit in the row and the output register.
// A nibble above 9 sets bad_digit and forces the result to zero; the
// reserved operation code gives a zero result.
`include "signed_bcd_add_sub_mul_assert.svh"
module signed_bcd_add_sub_mul
  import sbcd_pkg::*;
#(
  parameter int DIGITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  sbcd_req_if.sink in_ch,
  sbcd_res_if.source out_ch
);
  localparam int DW = 4*DIGITS;
  localparam int AW = COL_W*2*DIGITS;
  localparam int NN = (DIGITS > 1) ? DIGITS-1 : 1;

  logic en;
  logic [DW-1:0] am, bm;
  logic bad_a, bad_b;
  ctl_t dec_ctl;

  ctl_t ctl_c [DIGITS+1];
  logic [DW-1:0] a_c [DIGITS+1];
  logic [DW-1:0] b_c [DIGITS+1];
  logic [AW-1:0] acc_c [DIGITS+1];
  logic cy_c [DIGITS+1];

  ctl_t ctl_n [NN+1];
  logic [AW-1:0] acc_n [NN+1];

  logic out_valid_r;
  res_t out_r, out_nxt;
  ctl_t fin_ctl;
  logic [AW-1:0] fin_acc;
  logic [DW-1:0] lo, hi;
  logic beff;

  // row advances when output register is free or being taken
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // decode: mask, digit check, operation and sign set-up
  always_comb begin
    am = in_ch.data.a_magnitude[DW-1:0];
    bm = in_ch.data.b_magnitude[DW-1:0];
    bad_a = 1'b0;
    bad_b = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (am[4*i +: 4] > 4'd9) bad_a = 1'b1;
      if (bm[4*i +: 4] > 4'd9) bad_b = 1'b1;
    end
    beff = in_ch.data.b_negative ^ (in_ch.data.req_type == OP_SUB);
    dec_ctl.valid = in_ch.valid;
    dec_ctl.bad = bad_a | bad_b;
    dec_ctl.op = (bad_a | bad_b) ? OP_RSV : in_ch.data.req_type;
    dec_ctl.sub_mode = (in_ch.data.a_negative != beff);
    dec_ctl.swap = dec_ctl.sub_mode && (bm > am);
    case (in_ch.data.req_type)
      OP_MUL: dec_ctl.neg = in_ch.data.a_negative ^ in_ch.data.b_negative;
      OP_ADD, OP_SUB: dec_ctl.neg = dec_ctl.swap ? beff : in_ch.data.a_negative;
      default: dec_ctl.neg = 1'b0;
    endcase
  end

  assign ctl_c[0] = dec_ctl;
  assign a_c[0] = am;
  assign b_c[0] = bm;
  assign acc_c[0] = '0;
  assign cy_c[0] = 1'b0;

  // digit cells
  for (genvar g = 0; g < DIGITS; g++) begin : g_cell
    sbcd_cell #(.DIGITS(DIGITS), .POS(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_in(ctl_c[g]), .a_in(a_c[g]), .b_in(b_c[g]),
      .acc_in(acc_c[g]), .cy_in(cy_c[g]),
      .ctl_out(ctl_c[g+1]), .a_out(a_c[g+1]), .b_out(b_c[g+1]),
      .acc_out(acc_c[g+1]), .cy_out(cy_c[g+1])
    );
  end

  assign ctl_n[0] = ctl_c[DIGITS];
  assign acc_n[0] = acc_c[DIGITS];

  // carry normalising cells for the upper product columns
  for (genvar g = 0; g < DIGITS-1; g++) begin : g_norm
    sbcd_norm_cell #(.DIGITS(DIGITS), .POS(DIGITS+g)) u_norm (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_in(ctl_n[g]), .acc_in(acc_n[g]),
      .ctl_out(ctl_n[g+1]), .acc_out(acc_n[g+1])
    );
  end

  // single digit: no upper columns to settle
  if (DIGITS == 1) begin : g_pass
    assign ctl_n[1] = ctl_n[0];
    assign acc_n[1] = acc_n[0];
  end

  assign fin_ctl = ctl_n[NN];
  assign fin_acc = acc_n[NN];

  // pack columns into result digits
  always_comb begin
    lo = '0;
    hi = '0;
    for (int i = 0; i < DIGITS; i++) begin
      lo[4*i +: 4] = fin_acc[COL_W*i +: 4];
      hi[4*i +: 4] = fin_acc[COL_W*(DIGITS+i) +: 4];
    end
    out_nxt.result_low_digits = '0;
    out_nxt.result_high_digits = '0;
    out_nxt.result_low_digits[DW-1:0] = lo;
    out_nxt.result_high_digits[DW-1:0] = hi;
    out_nxt.bad_digit = fin_ctl.bad;
    out_nxt.result_negative = fin_ctl.neg && ((lo != '0) || (hi != '0));
    if (fin_ctl.op == OP_RSV) begin
      out_nxt.result_low_digits = '0;
      out_nxt.result_high_digits = '0;
      out_nxt.result_negative = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin_ctl.valid;
    end
    if (en) out_r <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  // checks
  `SBA_ASSERT_IMPL(a_hold, clk, rst_n,
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)),
    "result changed while stalled")
  `SBA_ASSERT_IMPL(a_ready, clk, rst_n,
    !out_ch.valid |-> in_ch.ready, "request refused with empty output")
  `SBA_ASSERT_IMPL(a_zero_pos, clk, rst_n,
    (out_ch.valid && out_ch.data.result_negative) |->
      (out_ch.data.result_low_digits != '0 || out_ch.data.result_high_digits != '0),
    "negative zero")
  `SBA_ASSERT_IMPL(a_bad_zero, clk, rst_n,
    (out_ch.valid && out_ch.data.bad_digit) |->
      (out_ch.data.result_low_digits == '0 && !out_ch.data.result_negative),
    "bad digit gave nonzero result")
endmodule

// ===== tb/signed_bcd_add_sub_mul_test.sv =====
// testbench for the signed bcd add, subtract and multiply unit
module signed_bcd_add_sub_mul_test;
  import sbcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS = 16;
  localparam int LATENCY = 2 * DIGITS + 1;

  logic clk;
  logic rst_n;

  sbcd_req_if in_ch();
  sbcd_res_if out_ch();

  signed_bcd_add_sub_mul #(.DIGITS(DIGITS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  res_t expected_results[$];
  int   fail_count = 0;
  int   results_checked = 0;
  int   requests_sent = 0;
  int   op_seen[4] = '{0, 0, 0, 0};
  int   bad_seen = 0;
  int   hold_cycles = 0;
  bit   gaps_on = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // expected sum, difference or product of two sign-magnitude bcd operands
  function automatic res_t predict_decimal(req_t r);
    int   da[DIGITS];
    int   db[DIGITS];
    int   acc[2*DIGITS];
    int   carry;
    int   s;
    bit   bad;
    bit   neg;
    bit   b_eff;
    bit   swap;
    res_t res;
    bad = 1'b0;
    neg = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      da[i] = int'(r.a_magnitude[4*i +: 4]);
      db[i] = int'(r.b_magnitude[4*i +: 4]);
      if (da[i] > 9 || db[i] > 9) bad = 1'b1;
    end
    for (int i = 0; i < 2*DIGITS; i++) acc[i] = 0;
    if (!bad && r.req_type == OP_MUL) begin
      for (int i = 0; i < DIGITS; i++)
        for (int j = 0; j < DIGITS; j++)
          acc[i+j] += da[i] * db[j];
      for (int i = 0; i + 1 < 2*DIGITS; i++) begin
        acc[i+1] += acc[i] / 10;
        acc[i] = acc[i] % 10;
      end
      neg = r.a_negative ^ r.b_negative;
    end else if (!bad && (r.req_type == OP_ADD || r.req_type == OP_SUB)) begin
      b_eff = r.b_negative ^ (r.req_type == OP_SUB);
      if (r.a_negative == b_eff) begin
        carry = 0;
        for (int i = 0; i < DIGITS; i++) begin
          s = da[i] + db[i] + carry;
          carry = (s >= 10);
          acc[i] = carry ? s - 10 : s;
        end
        acc[DIGITS] = carry;
        neg = r.a_negative;
      end else begin
        // larger magnitude minus smaller, sign follows the larger
        swap = r.b_magnitude > r.a_magnitude;
        neg = swap ? b_eff : r.a_negative;
        carry = 0;
        for (int i = 0; i < DIGITS; i++) begin
          s = (swap ? da[i] : db[i]) + carry;
          acc[i] = (swap ? db[i] : da[i]) - s;
          carry = (acc[i] < 0);
          if (carry) acc[i] += 10;
        end
      end
    end
    res = '0;
    for (int i = 0; i < DIGITS; i++) begin
      res.result_low_digits[4*i +: 4]  = acc[i][3:0];
      res.result_high_digits[4*i +: 4] = acc[DIGITS+i][3:0];
    end
    res.result_negative = neg && (res.result_low_digits != '0 ||
                                  res.result_high_digits != '0);
    res.bad_digit = bad;
    return res;
  endfunction

  // random magnitude of up to n digits
  function automatic logic [MAG_W-1:0] rand_bcd(int n);
    logic [MAG_W-1:0] v;
    v = '0;
    for (int i = 0; i < n && i < DIGITS; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  // send one request and record its expected result on acceptance
  task automatic send_request(req_t r);
    in_ch.data  <= r;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_decimal(r));
    requests_sent++;
    op_seen[r.req_type]++;
    if (expected_results[$].bad_digit) bad_seen++;
  endtask

  // idle the request side by dropping valid, when n is positive
  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic req_t make_req(op_t op, bit an, logic [MAG_W-1:0] am,
                                    bit bn, logic [MAG_W-1:0] bm);
    req_t r;
    r.req_type    = op;
    r.a_negative  = an;
    r.a_magnitude = am;
    r.b_negative  = bn;
    r.b_magnitude = bm;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   k;
    k = $urandom_range(0, 99);
    r.req_type    = (k < 4) ? OP_RSV : op_t'($urandom_range(0, 2));
    r.a_negative  = $urandom_range(0, 1);
    r.b_negative  = $urandom_range(0, 1);
    // most operands short so carries, borrows and equal values are common
    r.a_magnitude = rand_bcd(($urandom_range(0, 3) == 0) ? DIGITS : $urandom_range(0, 6));
    r.b_magnitude = rand_bcd(($urandom_range(0, 3) == 0) ? DIGITS : $urandom_range(0, 6));
    k = $urandom_range(0, 99);
    if (k < 8) r.b_magnitude = r.a_magnitude;
    else if (k < 14) r.a_magnitude[4*$urandom_range(0, DIGITS-1) +: 4] = 4'($urandom_range(10, 15));
    else if (k < 20) r.b_magnitude[4*$urandom_range(0, DIGITS-1) +: 4] = 4'($urandom_range(10, 15));
    return r;
  endfunction

  // result receiver: random stalls plus an optional long hold
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_ch.data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_ch.data.result_negative !== want.result_negative) begin
          $display("%0t: result_negative expected %b actual %b", $time,
                   want.result_negative, out_ch.data.result_negative);
          fail_count++;
        end
        if (out_ch.data.result_low_digits !== want.result_low_digits) begin
          $display("%0t: result_low_digits expected %h actual %h", $time,
                   want.result_low_digits, out_ch.data.result_low_digits);
          fail_count++;
        end
        if (out_ch.data.result_high_digits !== want.result_high_digits) begin
          $display("%0t: result_high_digits expected %h actual %h", $time,
                   want.result_high_digits, out_ch.data.result_high_digits);
          fail_count++;
        end
        if (out_ch.data.bad_digit !== want.bad_digit) begin
          $display("%0t: bad_digit expected %b actual %b", $time,
                   want.bad_digit, out_ch.data.bad_digit);
          fail_count++;
        end
      end
    end
  end

  // extremes, each operation, sign cases, bad digits, reserved operation
  task automatic test_directed();
    logic [MAG_W-1:0] nines;
    nines = 64'h9999_9999_9999_9999;
    send_request(make_req(OP_ADD, 0, '0, 0, '0));
    send_request(make_req(OP_ADD, 1, '0, 1, '0));
    send_request(make_req(OP_ADD, 0, nines, 0, nines));
    send_request(make_req(OP_ADD, 1, nines, 1, 64'h1));
    send_request(make_req(OP_SUB, 0, nines, 0, nines));
    send_request(make_req(OP_SUB, 1, nines, 1, nines));
    send_request(make_req(OP_ADD, 0, 64'h1234, 1, 64'h1234));
    send_request(make_req(OP_SUB, 0, 64'h1000_0000_0000_0000, 0, 64'h1));
    send_request(make_req(OP_SUB, 1, 64'h1, 0, 64'h1000_0000_0000_0000));
    send_request(make_req(OP_SUB, 0, 64'h5, 1, 64'h7));
    send_request(make_req(OP_ADD, 0, 64'h3, 1, 64'h8));
    send_request(make_req(OP_MUL, 0, nines, 0, nines));
    send_request(make_req(OP_MUL, 1, nines, 0, nines));
    send_request(make_req(OP_MUL, 1, 64'h25, 1, 64'h4));
    send_request(make_req(OP_MUL, 1, '0, 0, nines));
    send_request(make_req(OP_RSV, 1, nines, 1, nines));
    send_request(make_req(OP_RSV, 0, 64'hF, 0, 64'h1));
    send_request(make_req(OP_ADD, 0, 64'hF000_0000_0000_0000, 0, 64'h1));
    send_request(make_req(OP_SUB, 1, 64'h1, 1, 64'hA));
    send_request(make_req(OP_MUL, 0, '1, 1, '1));
    send_request(make_req(OP_ADD, 0, 64'h8888_8888_8888_8888, 1, 64'h1));
    idle_cycles(1);
  endtask

  // long random stream with gaps on both sides and quiet stretches
  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 100) gaps_on = 1'b0;
      if (i % 200 == 0) gaps_on = 1'b1;
      send_request(random_req());
      if (gaps_on) idle_cycles(pick_gap());
    end
    gaps_on = 1'b1;
    idle_cycles(1);
  endtask

  // receiver holds off while requests keep coming, so the row fills
  task automatic test_backpressure();
    hold_cycles = 4 * LATENCY;
    for (int i = 0; i < 3 * LATENCY; i++) send_request(random_req());
    idle_cycles(1);
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_request(random_req());
    idle_cycles(1);
    wait (expected_results.size() == 0);
    @(posedge clk);
    for (int i = 0; i < 20; i++) send_request(random_req());
    idle_cycles(1);
  endtask

  // test sequence
  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_stream(950);
    test_drain_pause();
    wait (expected_results.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
    $display("covered %0d requests (add %0d, sub %0d, mul %0d, reserved %0d, bad digit %0d)",
             requests_sent, op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
             op_seen[OP_RSV], bad_seen);
    $display("%0d results checked, with long receiver hold and full drain", results_checked);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== signed_bcd_add_sub_mul.f =====
+incdir+design
design/sbcd_pkg.sv
design/sbcd_if.sv
design/sbcd_cell.sv
design/sbcd_norm_cell.sv
design/signed_bcd_add_sub_mul.sv
tb/signed_bcd_add_sub_mul_test.sv
